[rtl/bsa_pkg.sv]
// Shared types, opcodes and constants of the 16-bit bit-slice ALU.
package bsa_pkg;

	localparam int NUM_REGS_DEF = 16;
	localparam int WORD_W       = 16;
	localparam int IDX_W        = 4;
	localparam int INSTR_W      = 9;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [INSTR_W-1:0] instr_t;

	// Operand pair (R,S)
	typedef enum logic [2:0] {
		SRC_AQ, SRC_AB, SRC_ZQ, SRC_ZB, SRC_ZA, SRC_DA, SRC_DQ, SRC_DZ
	} src_t;

	typedef enum logic [2:0] {
		FN_ADD, FN_SUBR, FN_SUBS, FN_OR, FN_AND, FN_NOTRS, FN_XOR, FN_XNOR
	} fn_t;

	typedef enum logic [2:0] {
		DST_QREG, DST_NOP, DST_RAMA, DST_RAMF, DST_RAMQD, DST_RAMD, DST_RAMQU, DST_RAMU
	} dst_t;

	localparam logic RAM_SHIFT_IN_DOWN = 1'b1;
	localparam logic Q_SHIFT_IN_DOWN   = 1'b0;
	localparam logic SHIFT_IN_UP       = 1'b0;

	// Write-back request from the execute logic
	typedef struct packed {
		logic  rf_we;
		logic  q_we;
		word_t rf_data;
		word_t q_data;
	} wb_t;

endpackage

[rtl/bsa_if.sv]
// Valid/ready channel interfaces for microinstructions and results.
interface bsa_cmd_if;
	logic          valid;
	logic          ready;
	bsa_pkg::instr_t instruction;
	bsa_pkg::idx_t a_index;
	bsa_pkg::idx_t b_index;
	bsa_pkg::word_t direct_data;
	logic          carry_in;

	modport source (output valid, instruction, a_index, b_index, direct_data, carry_in,
		input ready);
	modport sink (input valid, instruction, a_index, b_index, direct_data, carry_in,
		output ready);
endinterface

interface bsa_res_if;
	logic           valid;
	logic           ready;
	bsa_pkg::word_t alu_result;
	bsa_pkg::word_t y_out;

	modport source (output valid, alu_result, y_out, input ready);
	modport sink (input valid, alu_result, y_out, output ready);
endinterface

[rtl/bsa_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
module bsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data when no read is issued
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

[rtl/bsa_alu.sv]
// Operand select, ALU function and destination decode of one microinstruction.
module bsa_alu (
	input  bsa_pkg::instr_t instr,
	input  bsa_pkg::word_t  ra,
	input  bsa_pkg::word_t  rb,
	input  bsa_pkg::word_t  q,
	input  bsa_pkg::word_t  d,
	input  logic            c,
	output bsa_pkg::word_t  f,
	output bsa_pkg::word_t  y,
	output bsa_pkg::wb_t    wb
);
	import bsa_pkg::*;

	word_t r, s;
	logic [WORD_W:0] sum;

	always_comb begin
		case (src_t'(instr[2:0]))
			SRC_AQ: begin r = ra; s = q; end
			SRC_AB: begin r = ra; s = rb; end
			SRC_ZQ: begin r = '0; s = q; end
			SRC_ZB: begin r = '0; s = rb; end
			SRC_ZA: begin r = '0; s = ra; end
			SRC_DA: begin r = d; s = ra; end
			SRC_DQ: begin r = d; s = q; end
			default: begin r = d; s = '0; end
		endcase
	end

	always_comb begin
		sum = '0;
		case (fn_t'(instr[5:3]))
			FN_ADD: begin
				sum = {1'b0, r} + {1'b0, s} + {{WORD_W{1'b0}}, c};
				f = sum[WORD_W-1:0];
			end
			FN_SUBR: begin
				sum = {1'b0, ~r} + {1'b0, s} + {{WORD_W{1'b0}}, c};
				f = sum[WORD_W-1:0];
			end
			FN_SUBS: begin
				sum = {1'b0, r} + {1'b0, ~s} + {{WORD_W{1'b0}}, c};
				f = sum[WORD_W-1:0];
			end
			FN_OR:    f = r | s;
			FN_AND:   f = r & s;
			FN_NOTRS: f = ~r & s;
			FN_XOR:   f = r ^ s;
			default:  f = ~(r ^ s);
		endcase
	end

	always_comb begin
		y          = f;
		wb.rf_we   = 1'b1;
		wb.q_we    = 1'b0;
		wb.rf_data = f;
		wb.q_data  = f;
		case (dst_t'(instr[8:6]))
			DST_QREG: begin
				wb.rf_we = 1'b0;
				wb.q_we  = 1'b1;
			end
			DST_NOP: wb.rf_we = 1'b0;
			DST_RAMA: y = ra;
			DST_RAMF: ;
			DST_RAMQD: begin
				wb.rf_data = {RAM_SHIFT_IN_DOWN, f[WORD_W-1:1]};
				wb.q_we    = 1'b1;
				wb.q_data  = {Q_SHIFT_IN_DOWN, q[WORD_W-1:1]};
			end
			DST_RAMD: wb.rf_data = {RAM_SHIFT_IN_DOWN, f[WORD_W-1:1]};
			DST_RAMQU: begin
				wb.rf_data = {f[WORD_W-2:0], SHIFT_IN_UP};
				wb.q_we    = 1'b1;
				wb.q_data  = {q[WORD_W-2:0], SHIFT_IN_UP};
			end
			default: wb.rf_data = {f[WORD_W-2:0], SHIFT_IN_UP};
		endcase
	end
endmodule

[rtl/bit_slice_alu_16bit.sv]
// Top level of the 16-bit bit-slice ALU with register file and Q register.
//
// cmd carries one microinstruction per transaction: instruction (destination,
// function, source pair), A and B register indices, direct data and carry in.
// res returns one transaction per microinstruction: F and Y.
// The register file lives in a RAM with two registered read ports. A and B
// are read in the cycle an item is accepted; when execute may advance, it
// selects operands, computes F and writes Q, register B or both back while
// loading the output register. The item passes the execute register and the
// output register before res.valid rises.
// Throughput is one item per cycle while res does not stall: the RAM read of
// the next item overlaps the write-back of the current one, and a bypass
// register supplies the value just written when the indices collide.
// Reset clears Q and the valid flags (execute, bypass, output, one per entry);
// an entry never written since reset reads as zero, so no clearing pass runs.
// When res stalls, one item waits in execute and one in the output register;
// cmd.ready then drops until res takes a transaction.
module bit_slice_alu_16bit #(
	parameter int NUM_REGISTERS = bsa_pkg::NUM_REGS_DEF
) (
	input logic clk,
	input logic arst_n,
	bsa_cmd_if.sink   cmd,
	bsa_res_if.source res
);
	import bsa_pkg::*;

	localparam int AddrW = $clog2(NUM_REGISTERS);

	logic                 accept;
	logic                 adv;
	logic                 rf_we;
	word_t                rdata_a, rdata_b;
	word_t                ra, rb, f, y;
	wb_t                  wb;

	logic                 v_s1;
	instr_t               instr_s1;
	logic [AddrW-1:0]     a_s1, b_s1;
	word_t                d_s1;
	logic                 c_s1;
	logic                 va_s1, vb_s1;

	logic [NUM_REGISTERS-1:0] vld_q;
	logic                 wr_vld_q;
	logic [AddrW-1:0]     wr_addr_q;
	word_t                wr_data_q;
	word_t                q_q;

	logic                 out_vld_q;
	word_t                out_f_q, out_y_q;

	assign adv       = v_s1 && (!out_vld_q || res.ready);
	assign cmd.ready = !v_s1 || adv;
	assign accept    = cmd.valid && cmd.ready;
	assign rf_we     = adv && wb.rf_we;

	bsa_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_REGISTERS)
	) u_rf (
		.clk     (clk),
		.we      (rf_we),
		.waddr   (b_s1),
		.wdata   (wb.rf_data),
		.re      (accept),
		.raddr_a (cmd.a_index[AddrW-1:0]),
		.raddr_b (cmd.b_index[AddrW-1:0]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// bypass the previous write, else unwritten entries read as zero
	always_comb begin
		if (wr_vld_q && wr_addr_q == a_s1) begin
			ra = wr_data_q;
		end else begin
			ra = va_s1 ? rdata_a : '0;
		end
		if (wr_vld_q && wr_addr_q == b_s1) begin
			rb = wr_data_q;
		end else begin
			rb = vb_s1 ? rdata_b : '0;
		end
	end

	bsa_alu u_alu (
		.instr (instr_s1),
		.ra    (ra),
		.rb    (rb),
		.q     (q_q),
		.d     (d_s1),
		.c     (c_s1),
		.f     (f),
		.y     (y),
		.wb    (wb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			vld_q     <= '0;
			wr_vld_q  <= 1'b0;
			q_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				wr_vld_q <= wb.rf_we;
				if (wb.rf_we) begin
					vld_q[b_s1] <= 1'b1;
				end
				if (wb.q_we) begin
					q_q <= wb.q_data;
				end
			end
			if (adv) begin
				out_vld_q <= 1'b1;
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= cmd.instruction;
			a_s1     <= cmd.a_index[AddrW-1:0];
			b_s1     <= cmd.b_index[AddrW-1:0];
			d_s1     <= cmd.direct_data;
			c_s1     <= cmd.carry_in;
			va_s1    <= vld_q[cmd.a_index[AddrW-1:0]];
			vb_s1    <= vld_q[cmd.b_index[AddrW-1:0]];
		end
		if (adv) begin
			wr_addr_q <= b_s1;
			wr_data_q <= wb.rf_data;
			out_f_q   <= f;
			out_y_q   <= y;
		end
	end

	assign res.valid      = out_vld_q;
	assign res.alu_result = out_f_q;
	assign res.y_out      = out_y_q;

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res.valid |-> cmd.ready)
		else $error("cmd.ready low with an empty output register");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.valid && !res.ready) |=> (res.ready || !cmd.ready))
		else $error("second item taken while output stalled");

	a_written_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rf_we |=> vld_q[$past(b_s1)])
		else $error("register write left entry marked unwritten");

endmodule
